// File: rtl/wcc_pkg.sv
// Package for the window contrast counter: shared constants and types.
`timescale 1ns / 1ps
package wcc_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HALF   = 15;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int CFG_WIDTH_BITS  = 12;
    localparam int CFG_HALF_BITS   = 4;
    localparam int CFG_THR_BITS    = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CMP_BITS        = 13;
    localparam int ROW_BITS        = 11;
    localparam int HEIGHT_LIMIT    = 2048;
    localparam int COUNT_BITS      = 23;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WIDTH     = 2'd0,
        REG_HEIGHT    = 2'd1,
        REG_HALF      = 2'd2,
        REG_THRESHOLD = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HRD  = 5'b00010,
        S_HWR  = 5'b00100,
        S_VRD  = 5'b01000,
        S_FIN  = 5'b10000
    } wcc_state_t;

endpackage

// File: rtl/window_contrast_counter.sv
// Top level of the window contrast counter: control sequencer and line stores.
// Per request: accept in idle, walk the row buffer (S_HRD), write the row run to the
// line max/min store (S_HWR), walk that store (S_VRD), load the result (S_FIN); a walk
// is skipped when its run is shorter than side (side = 2*half_window+1). The walks issue
// one memory read per cycle. One request is in work at a time; S_FIN waits for out_ready.
// Reset: asynchronous, active low; clears position, count, state and restores register
// defaults. The memories are not cleared and hold stale data until written.
`timescale 1ns / 1ps
module window_contrast_counter
    import wcc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HALF   = DEF_MAX_HALF,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [PIXEL_BITS-1:0]     pixel,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      window_valid,
    output logic [PIXEL_BITS-1:0]     window_max,
    output logic [PIXEL_BITS-1:0]     window_min,
    output logic                      contrast_hit,
    output logic [COUNT_BITS-1:0]     hit_count,
    output logic                      frame_end
);

    localparam int WIN_SLOTS = 2 * MAX_HALF + 1;
    localparam int SLOT_BITS = (WIN_SLOTS > 1) ? $clog2(WIN_SLOTS) : 1;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int SIDE_BITS = $clog2(2 * MAX_HALF + 2);
    localparam int LINE_DEPTH = WIN_SLOTS * (1 << COL_BITS);
    localparam int LINE_ABITS = SLOT_BITS + COL_BITS;
    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(WIN_SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [CFG_WIDTH_BITS-1:0] cfg_width_reg;
    logic [CFG_WIDTH_BITS-1:0] cfg_height_reg;
    logic [CFG_HALF_BITS-1:0]  cfg_half_reg;
    logic [CFG_THR_BITS-1:0]   cfg_thr_reg;

    // control and datapath registers
    wcc_state_t state_reg, state_next;
    logic [COL_BITS-1:0]   col_reg, col_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;
    logic [SLOT_BITS-1:0]  col_slot_reg, col_slot_next;
    logic [SLOT_BITS-1:0]  row_slot_reg, row_slot_next;
    logic [SLOT_BITS-1:0]  rd_slot_reg, rd_slot_next;
    logic [SIDE_BITS-1:0]  iss_reg, iss_next;
    logic [SIDE_BITS-1:0]  rcv_reg, rcv_next;
    logic                  pend_reg, pend_next;
    logic [PIXEL_BITS-1:0] acc_max_reg, acc_max_next;
    logic [PIXEL_BITS-1:0] acc_min_reg, acc_min_next;
    logic                  win_ok_reg, win_ok_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic                  o_wvalid_reg, o_wvalid_next;
    logic [PIXEL_BITS-1:0] o_max_reg, o_max_next;
    logic [PIXEL_BITS-1:0] o_min_reg, o_min_next;
    logic                  o_hit_reg, o_hit_next;
    logic [COUNT_BITS-1:0] o_count_reg, o_count_next;
    logic                  o_fend_reg, o_fend_next;

    // memories
    logic                    rb_we;
    logic [PIXEL_BITS-1:0]   rb_rdata;
    logic                    lb_we;
    logic [LINE_ABITS-1:0]   lb_waddr;
    logic [LINE_ABITS-1:0]   lb_raddr;
    logic [2*PIXEL_BITS-1:0] lb_rdata;

    // effective geometry (zero reads as one, oversize is clamped)
    logic [CMP_BITS-1:0]  width_eff;
    logic [CMP_BITS-1:0]  height_eff;
    logic [6:0]           half_wide;
    logic [SIDE_BITS-1:0] side;
    logic [CMP_BITS-1:0]  col_p1;
    logic [CMP_BITS-1:0]  row_p1;
    logic                 col_run_ok;
    logic                 row_run_ok;
    logic                 last_col;
    logic                 last_row;
    logic                 in_fire;
    logic                 out_load;
    logic                 issue;
    logic                 last_rcv;
    logic [PIXEL_BITS-1:0] samp_max;
    logic [PIXEL_BITS-1:0] samp_min;
    logic [31:0]          diff_wide;
    logic                 hit;

    always_comb
    begin
        width_eff = CMP_BITS'(cfg_width_reg);
        if (cfg_width_reg == '0)
        begin
            width_eff = CMP_BITS'(1);
        end
        else if (CMP_BITS'(cfg_width_reg) > CMP_BITS'(MAX_WIDTH))
        begin
            width_eff = CMP_BITS'(MAX_WIDTH);
        end
        height_eff = CMP_BITS'(cfg_height_reg);
        if (cfg_height_reg == '0)
        begin
            height_eff = CMP_BITS'(1);
        end
        else if (CMP_BITS'(cfg_height_reg) > CMP_BITS'(HEIGHT_LIMIT))
        begin
            height_eff = CMP_BITS'(HEIGHT_LIMIT);
        end
        half_wide = 7'(cfg_half_reg);
        if (half_wide > 7'(MAX_HALF))
        begin
            half_wide = 7'(MAX_HALF);
        end
    end

    assign side       = SIDE_BITS'({half_wide, 1'b1});
    assign col_p1     = CMP_BITS'(col_reg) + CMP_BITS'(1);
    assign row_p1     = CMP_BITS'(row_reg) + CMP_BITS'(1);
    assign col_run_ok = col_p1 >= CMP_BITS'(side);
    assign row_run_ok = row_p1 >= CMP_BITS'(side);
    assign last_col   = col_p1 >= width_eff;
    assign last_row   = row_p1 >= height_eff;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    // one read issued per cycle, its data returns in the following cycle
    assign issue    = (iss_reg != side);
    assign last_rcv = pend_reg && (rcv_reg == side - SIDE_BITS'(1));

    // row walk folds one pixel into both; line walk folds stored max and min
    assign samp_max = (state_reg == S_VRD) ? lb_rdata[2*PIXEL_BITS-1:PIXEL_BITS] : rb_rdata;
    assign samp_min = (state_reg == S_VRD) ? lb_rdata[PIXEL_BITS-1:0] : rb_rdata;

    assign diff_wide = 32'(acc_max_reg - acc_min_reg);
    assign hit       = win_ok_reg && (diff_wide >= 32'(cfg_thr_reg));

    assign rb_we    = in_fire;
    assign lb_we    = (state_reg == S_HWR);
    assign lb_waddr = {row_slot_reg, col_reg};
    assign lb_raddr = {rd_slot_reg, col_reg};

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        col_slot_next  = col_slot_reg;
        row_slot_next  = row_slot_reg;
        rd_slot_next   = rd_slot_reg;
        iss_next       = iss_reg;
        rcv_next       = rcv_reg;
        pend_next      = 1'b0;
        acc_max_next   = acc_max_reg;
        acc_min_next   = acc_min_reg;
        win_ok_next    = win_ok_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_wvalid_next  = o_wvalid_reg;
        o_max_next     = o_max_reg;
        o_min_next     = o_min_reg;
        o_hit_next     = o_hit_reg;
        o_count_next   = o_count_reg;
        o_fend_next    = o_fend_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    rd_slot_next = col_slot_reg;
                    iss_next     = '0;
                    rcv_next     = '0;
                    acc_max_next = '0;
                    acc_min_next = '1;
                    win_ok_next  = 1'b0;
                    state_next   = col_run_ok ? S_HRD : S_FIN;
                end
            end
            S_HRD, S_VRD:
            begin
                if (issue)
                begin
                    iss_next     = iss_reg + SIDE_BITS'(1);
                    rd_slot_next = (rd_slot_reg == '0) ? SLOT_LAST
                                                       : rd_slot_reg - SLOT_BITS'(1);
                    pend_next    = 1'b1;
                end
                if (pend_reg)
                begin
                    rcv_next = rcv_reg + SIDE_BITS'(1);
                    if (samp_max > acc_max_reg)
                    begin
                        acc_max_next = samp_max;
                    end
                    if (samp_min < acc_min_reg)
                    begin
                        acc_min_next = samp_min;
                    end
                end
                if (last_rcv)
                begin
                    pend_next = 1'b0;
                    if (state_reg == S_HRD)
                    begin
                        state_next = S_HWR;
                    end
                    else
                    begin
                        win_ok_next = 1'b1;
                        state_next  = S_FIN;
                    end
                end
            end
            S_HWR:
            begin
                // horizontal run is written this cycle, then the column walk starts if the row run is long enough
                rd_slot_next = row_slot_reg;
                iss_next     = '0;
                rcv_next     = '0;
                acc_max_next = '0;
                acc_min_next = '1;
                state_next   = row_run_ok ? S_VRD : S_FIN;
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    if (hit && (total_reg != COUNT_MAX))
                    begin
                        total_next = total_reg + COUNT_BITS'(1);
                    end
                    out_valid_next = 1'b1;
                    o_wvalid_next  = win_ok_reg;
                    o_max_next     = win_ok_reg ? acc_max_reg : '0;
                    o_min_next     = win_ok_reg ? acc_min_reg : '0;
                    o_hit_next     = hit;
                    o_count_next   = total_next;
                    o_fend_next    = last_col && last_row;
                    if (last_col)
                    begin
                        col_next      = '0;
                        col_slot_next = '0;
                        if (last_row)
                        begin
                            row_next      = '0;
                            row_slot_next = '0;
                            total_next    = '0;
                        end
                        else
                        begin
                            row_next      = row_reg + ROW_BITS'(1);
                            row_slot_next = (row_slot_reg == SLOT_LAST) ? '0
                                            : row_slot_reg + SLOT_BITS'(1);
                        end
                    end
                    else
                    begin
                        col_next      = col_reg + COL_BITS'(1);
                        col_slot_next = (col_slot_reg == SLOT_LAST) ? '0
                                        : col_slot_reg + SLOT_BITS'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= CFG_WIDTH_BITS'(640);
            cfg_height_reg <= CFG_WIDTH_BITS'(480);
            cfg_half_reg   <= CFG_HALF_BITS'(1);
            cfg_thr_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:     cfg_width_reg  <= cfg_data[CFG_WIDTH_BITS-1:0];
                REG_HEIGHT:    cfg_height_reg <= cfg_data[CFG_WIDTH_BITS-1:0];
                REG_HALF:      cfg_half_reg   <= cfg_data[CFG_HALF_BITS-1:0];
                REG_THRESHOLD: cfg_thr_reg    <= cfg_data[CFG_THR_BITS-1:0];
                default:       cfg_thr_reg    <= cfg_thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            col_slot_reg  <= '0;
            row_slot_reg  <= '0;
            iss_reg       <= '0;
            rcv_reg       <= '0;
            pend_reg      <= 1'b0;
            win_ok_reg    <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            col_slot_reg  <= col_slot_next;
            row_slot_reg  <= row_slot_next;
            iss_reg       <= iss_next;
            rcv_reg       <= rcv_next;
            pend_reg      <= pend_next;
            win_ok_reg    <= win_ok_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        rd_slot_reg  <= rd_slot_next;
        acc_max_reg  <= acc_max_next;
        acc_min_reg  <= acc_min_next;
        o_wvalid_reg <= o_wvalid_next;
        o_max_reg    <= o_max_next;
        o_min_reg    <= o_min_next;
        o_hit_reg    <= o_hit_next;
        o_count_reg  <= o_count_next;
        o_fend_reg   <= o_fend_next;
    end

    // last pixels of the current row, one slot per column modulo the slot count
    wcc_ram #(
        .DEPTH (WIN_SLOTS),
        .WIDTH (PIXEL_BITS),
        .ABITS (SLOT_BITS)
    ) u_row_buf (
        .clk   (clk),
        .we    (rb_we),
        .waddr (col_slot_reg),
        .wdata (pixel),
        .raddr (rd_slot_reg),
        .rdata (rb_rdata)
    );

    // horizontal max/min per row slot and column
    wcc_ram #(
        .DEPTH (LINE_DEPTH),
        .WIDTH (2 * PIXEL_BITS),
        .ABITS (LINE_ABITS)
    ) u_line_buf (
        .clk   (clk),
        .we    (lb_we),
        .waddr (lb_waddr),
        .wdata ({acc_max_reg, acc_min_reg}),
        .raddr (lb_raddr),
        .rdata (lb_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign window_valid = o_wvalid_reg;
    assign window_max   = o_max_reg;
    assign window_min   = o_min_reg;
    assign contrast_hit = o_hit_reg;
    assign hit_count    = o_count_reg;
    assign frame_end    = o_fend_reg;

endmodule

// File: rtl/wcc_ram.sv
// Simple dual-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module wcc_ram #(
    parameter int DEPTH = 31,
    parameter int WIDTH = 16,
    parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [ABITS-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [ABITS-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/wcc_checker.sv
// Port-level checker for the window contrast counter, with its bind.
`timescale 1ns / 1ps
module wcc_checker
    import wcc_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  window_valid,
    input logic [PIXEL_BITS-1:0] window_max,
    input logic [PIXEL_BITS-1:0] window_min,
    input logic                  contrast_hit
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before accept");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous still in work");

    a_hit_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && contrast_hit |-> window_valid)
        else $error("hit without full window");

    a_empty_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_valid |-> (window_max == '0) && (window_min == '0))
        else $error("nonzero max/min without window");

endmodule

bind window_contrast_counter wcc_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_wcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .window_valid (window_valid),
    .window_max   (window_max),
    .window_min   (window_min),
    .contrast_hit (contrast_hit)
);

// File: tb/window_contrast_counter_checker.sv
// Checker for the window contrast counter: watches the channels, predicts and compares.
`timescale 1ns / 1ps
module window_contrast_counter_checker
    import wcc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [15:0]               pixel,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      window_valid,
    input  logic [15:0]               window_max,
    input  logic [15:0]               window_min,
    input  logic                      contrast_hit,
    input  logic [COUNT_BITS-1:0]     hit_count,
    input  logic                      frame_end,
    output int                        fail_count,
    output int                        pending
);

    localparam int SLOTS = 31;
    localparam int LINE_LEN = 2048;
    localparam int FIFO_DEPTH = 16;

    typedef struct {
        bit                  win_ok;
        bit [15:0]           win_max;
        bit [15:0]           win_min;
        bit                  hit;
        bit [COUNT_BITS-1:0] count;
        bit                  last;
    } window_result_t;

    // expected results in request order
    window_result_t expected_windows [FIFO_DEPTH];
    int wr_ptr;
    int rd_ptr;
    int fill;

    bit [11:0] width_reg;
    bit [11:0] height_reg;
    bit [3:0]  half_reg;
    bit [15:0] thr_reg;

    int col_pos;
    int row_pos;
    bit [COUNT_BITS-1:0] flagged;

    bit [15:0] row_pixels [SLOTS];
    bit [15:0] run_max [SLOTS][LINE_LEN];
    bit [15:0] run_min [SLOTS][LINE_LEN];

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 100)
            $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Window max/min, hit and count over the square ending at the current raster position; advances it.
    task automatic predict_window(input bit [15:0] px, output window_result_t r);
        int w;
        int h;
        int side;
        int slot;
        int s;
        bit [15:0] hmax;
        bit [15:0] hmin;
        bit [15:0] vmax;
        bit [15:0] vmin;
        w = (width_reg == 0) ? 1 : ((width_reg > LINE_LEN) ? LINE_LEN : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
        side = 2 * half_reg + 1;
        slot = row_pos % SLOTS;
        r.win_ok = 0;
        r.win_max = 0;
        r.win_min = 0;
        r.hit = 0;
        row_pixels[col_pos % SLOTS] = px;
        if (col_pos + 1 >= side)
        begin
            hmax = 0;
            hmin = '1;
            for (int i = 0; i < side; i++)
            begin
                if (row_pixels[(col_pos - i) % SLOTS] > hmax) hmax = row_pixels[(col_pos - i) % SLOTS];
                if (row_pixels[(col_pos - i) % SLOTS] < hmin) hmin = row_pixels[(col_pos - i) % SLOTS];
            end
            run_max[slot][col_pos] = hmax;
            run_min[slot][col_pos] = hmin;
            if (row_pos + 1 >= side)
            begin
                vmax = 0;
                vmin = '1;
                for (int i = 0; i < side; i++)
                begin
                    s = (row_pos + SLOTS - i) % SLOTS;
                    if (run_max[s][col_pos] > vmax) vmax = run_max[s][col_pos];
                    if (run_min[s][col_pos] < vmin) vmin = run_min[s][col_pos];
                end
                r.win_ok = 1;
                r.win_max = vmax;
                r.win_min = vmin;
                r.hit = (vmax - vmin) >= thr_reg;
                if (r.hit && flagged != '1) flagged++;
            end
        end
        r.count = flagged;
        r.last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos + 1 >= h)
            begin
                row_pos = 0;
                flagged = 0;
            end
            else
                row_pos++;
        end
        else
            col_pos++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t r;
        window_result_t want;
        if (!rst_n)
        begin
            width_reg = 12'd640;
            height_reg = 12'd480;
            half_reg = 4'd1;
            thr_reg = 16'd0;
            col_pos = 0;
            row_pos = 0;
            flagged = 0;
            wr_ptr = 0;
            rd_ptr = 0;
            fill = 0;
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_WIDTH:     width_reg = cfg_data[11:0];
                    REG_HEIGHT:    height_reg = cfg_data[11:0];
                    REG_HALF:      half_reg = cfg_data[3:0];
                    REG_THRESHOLD: thr_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_window(pixel, r);
                if (fill == FIFO_DEPTH)
                    report_mismatch("expected result overflow, fill", fill, FIFO_DEPTH);
                else
                begin
                    expected_windows[wr_ptr] = r;
                    wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
                    fill++;
                end
            end
            if (out_valid && out_ready)
            begin
                if (fill == 0)
                    report_mismatch("unexpected result, window_valid", window_valid, 0);
                else
                begin
                    want = expected_windows[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
                    fill--;
                    if (window_valid !== want.win_ok)
                        report_mismatch("window_valid", window_valid, want.win_ok);
                    if (window_max !== want.win_max)
                        report_mismatch("window_max", window_max, want.win_max);
                    if (window_min !== want.win_min)
                        report_mismatch("window_min", window_min, want.win_min);
                    if (contrast_hit !== want.hit)
                        report_mismatch("contrast_hit", contrast_hit, want.hit);
                    if (hit_count !== want.count)
                        report_mismatch("hit_count", hit_count, want.count);
                    if (frame_end !== want.last)
                        report_mismatch("frame_end", frame_end, want.last);
                end
            end
            pending <= fill;
        end
    end

endmodule

// File: tb/window_contrast_counter_tb.sv
// Testbench top for the window contrast counter: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module window_contrast_counter_tb;
    import wcc_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [15:0]               pixel;
    logic                      out_valid;
    logic                      out_ready;
    logic                      window_valid;
    logic [15:0]               window_max;
    logic [15:0]               window_min;
    logic                      contrast_hit;
    logic [COUNT_BITS-1:0]     hit_count;
    logic                      frame_end;

    int fail_count;
    int pending;

    // flow control knobs, percent of cycles spent idle / stalled
    int send_idle_pct;
    int recv_stall_pct;
    // long receiver hold-off: set by the stimulus, consumed by the receiver
    bit hold_start;
    int hold_left;
    int pixels_sent;

    window_contrast_counter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_valid (window_valid),
        .window_max   (window_max),
        .window_min   (window_min),
        .contrast_hit (contrast_hit),
        .hit_count    (hit_count),
        .frame_end    (frame_end)
    );

    window_contrast_counter_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_valid (window_valid),
        .window_max   (window_max),
        .window_min   (window_min),
        .contrast_hit (contrast_hit),
        .hit_count    (hit_count),
        .frame_end    (frame_end),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off so the block backs up into its input.
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Four register writes back to back; valid stays high across them.
    task automatic write_config(input int w, input int h, input int half, input int thr);
        cfg_reg_t regs [4];
        int vals [4];
        regs = '{REG_WIDTH, REG_HEIGHT, REG_HALF, REG_THRESHOLD};
        vals = '{w, h, half, thr};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= CFG_DATA_BITS'(vals[i]);
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // One pixel request; random gap first, valid held until accepted.
    task automatic send_pixel(input bit [15:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= value;
        do @(posedge clk); while (!in_ready);
        pixels_sent++;
    endtask

    // Whole frame: config changes only when the block is drained and at frame start,
    // so every window reads store entries written in this frame.
    task automatic send_frame(input int w, input int h, input int half, input int thr,
                              input int pix_mode);
        int n;
        int ew;
        int eh;
        bit [15:0] v;
        // one edge first so the pending count includes the last accepted request
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        write_config(w, h, half, thr);
        ew = (w == 0) ? 1 : ((w > 2048) ? 2048 : w);
        eh = (h == 0) ? 1 : ((h > 2048) ? 2048 : h);
        n = ew * eh;
        for (int i = 0; i < n; i++)
        begin
            case (pix_mode)
                0: v = 16'($urandom);
                1: v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default: v = 16'($urandom_range(255));
            endcase
            send_pixel(v);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int frame_no;
        int w;
        int h;
        int half;
        int thr;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_start = 1'b0;
        hold_left = 0;
        pixels_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme pixels, degenerate sizes, windows that never complete
        send_frame(3, 3, 1, 0, 1);
        send_frame(0, 0, 0, 65535, 0);
        send_frame(2, 2, 1, 100, 1);
        send_frame(4, 2, 0, 65535, 1);

        // random frames, idling phase rotates per frame
        frame_no = 0;
        while (pixels_sent < 380 || frame_no < 4)
        begin
            case (frame_no % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if ($urandom_range(5) == 0)
            begin
                half = $urandom_range(4, 6);
                w = 2 * half + 1 + $urandom_range(3);
                h = 2 * half + 1 + $urandom_range(1);
            end
            else
            begin
                half = $urandom_range(3);
                w = $urandom_range(1, 16);
                h = $urandom_range(1, 10);
            end
            case ($urandom_range(3))
                0: thr = 0;
                1: thr = 65535;
                2: thr = $urandom_range(65535);
                default: thr = $urandom_range(300);
            endcase
            if (frame_no == 2)
            begin
                // fill the block while the receiver sits still
                send_idle_pct = 0;
                hold_start = 1'b1;
                w = 20;
                h = 8;
            end
            send_frame(w, h, half, thr, $urandom_range(2));
            frame_no++;
        end

        // largest window
        send_idle_pct = 35;
        recv_stall_pct = 35;
        send_frame(31, 31, 15, $urandom_range(65535), 2);

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
        if (fail_count == 0)
            $display("window_contrast_counter: match");
        else
            $display("window_contrast_counter: mismatch");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("window_contrast_counter: mismatch");
        $finish;
    end

endmodule
